FILE: hw/rtl/gta_pkg.sv
// Shared constants, types and tanh table builders for the GELU tanh activation core.
package gta_pkg;

  localparam int unsigned DataW           = 16;
  localparam int unsigned MagW            = 16;
  localparam int unsigned TanhSegmentsDef = 64;
  localparam int unsigned TanhSegmentsMax = 1024;
  localparam int unsigned TabIdxW         = $clog2(TanhSegmentsMax + 1);

  localparam int unsigned PolyStages = 5;
  localparam int unsigned TanhStages = 2;
  localparam int unsigned OutStages  = 1;
  localparam int unsigned NumStages  = PolyStages + TanhStages + OutStages;

  // Fixed-point widths along the datapath
  localparam int unsigned SqW    = 32;  // a^2, Q.24
  localparam int unsigned CubeW  = 48;  // a^3, Q.36 (value below 2^46)
  localparam int unsigned C12W   = 34;  // a^3 >> 12
  localparam int unsigned InnerW = 29;  // x + 0.044715 x^3, Q.24
  localparam int unsigned UW     = 29;  // tanh argument, Q.24
  localparam int unsigned SpanW  = 26;  // tanh span [0,4) in Q.24
  localparam int unsigned TanhW  = 25;  // tanh, Q.24, up to 1.0
  localparam int unsigned SlopeW = 22;  // per-segment rise, below 2^22 for 16+ segments

  localparam logic [19:0]       AlphaQ24 = 20'd750193;
  localparam logic [23:0]       BetaQ24  = 24'd13386282;
  localparam logic [TanhW-1:0]  OneQ24   = TanhW'(1) << 24;
  localparam logic [63:0]       OneQ30   = 64'd1 << 30;

  typedef logic [TanhSegmentsMax:0][TanhW-1:0] tanh_tab_t;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } gta_side_t;

  // Shift-subtract division, only used while building tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-2u) in Q.30 from w = 2u/16: 16-term series, then squared four times
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] w);
    logic [63:0] term;
    logic [63:0] sum;
    logic [31:0] n_v;
    term = OneQ30;
    sum  = OneQ30;
    for (int n = 1; n <= 16; n++) begin
      n_v  = 32'(n);
      term = udiv64((term * w) >> 30, 64'(n_v));
      if (n_v[0]) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int i = 0; i < 4; i++) begin
      sum = (sum * sum) >> 30;
    end
    return sum;
  endfunction

  // tanh(4k/segs) in Q.24 for k = 0 .. segs, forced non-decreasing
  function automatic tanh_tab_t tanh_table(input int unsigned segs);
    tanh_tab_t   tab;
    logic [63:0] w;
    logic [63:0] e;
    logic [63:0] y;
    logic [63:0] prev;
    logic [31:0] k_v;
    tab  = '0;
    prev = '0;
    for (int unsigned k = 0; k <= segs; k++) begin
      k_v = 32'(k);
      w   = udiv64(64'(k_v) << 29, 64'(segs));
      e   = exp_neg_q30(w);
      if (e > OneQ30) begin
        e = OneQ30;
      end
      y = udiv64((OneQ30 - e) << 24, OneQ30 + e);
      if (k > 0 && y < prev) begin
        y = prev;
      end
      tab[k_v[TabIdxW-1:0]] = TanhW'(y);
      prev = y;
    end
    return tab;
  endfunction

  // Rise of each segment: tab[k+1] - tab[k]
  function automatic tanh_tab_t slope_table(input tanh_tab_t tab, input int unsigned segs);
    tanh_tab_t   sl;
    logic [31:0] k_v;
    sl = '0;
    for (int unsigned k = 0; k < segs; k++) begin
      k_v = 32'(k);
      sl[k_v[TabIdxW-1:0]] = tab[k_v[TabIdxW-1:0] + TabIdxW'(1)] - tab[k_v[TabIdxW-1:0]];
    end
    return sl;
  endfunction

endpackage

FILE: hw/rtl/gta_poly.sv
// Magnitude, cubic polynomial and tanh argument stages.
module gta_poly
  import gta_pkg::*;
(
  input  logic                  clk_i,
  input  logic [PolyStages-1:0] en_i,
  input  logic [DataW-1:0]      sample_i,
  output logic [UW-1:0]         u_o,
  output gta_side_t             side_o
);

  gta_side_t          side_q [PolyStages];
  logic [MagW-1:0]    mag_d;
  logic [SqW-1:0]     sq_q;
  logic [CubeW-1:0]   cube_d;
  logic [C12W-1:0]    c12_q;
  logic [53:0]        cterm_d;
  logic [InnerW-1:0]  inner_d;
  logic [InnerW-1:0]  inner_q;
  logic [52:0]        uprod_d;
  logic [UW-1:0]      u_q;

  // -32768 maps to magnitude 32768, which still fits 16 unsigned bits
  assign mag_d   = sample_i[DataW-1] ? MagW'(~sample_i + 16'd1) : MagW'(sample_i);
  assign cube_d  = CubeW'(sq_q) * CubeW'(side_q[1].mag);
  assign cterm_d = 54'(c12_q) * 54'(AlphaQ24);
  // sum stays below 2^29 over the whole input range
  assign inner_d = InnerW'({side_q[2].mag, 12'b0}) + InnerW'(cterm_d[53:24]);
  assign uprod_d = 53'(inner_q) * 53'(BetaQ24);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_q[0] <= '{neg: sample_i[DataW-1], mag: mag_d};
    end
    if (en_i[1]) begin
      side_q[1] <= side_q[0];
      sq_q      <= SqW'(side_q[0].mag) * SqW'(side_q[0].mag);
    end
    if (en_i[2]) begin
      side_q[2] <= side_q[1];
      c12_q     <= cube_d[45:12];
    end
    if (en_i[3]) begin
      side_q[3] <= side_q[2];
      inner_q   <= inner_d;
    end
    if (en_i[4]) begin
      side_q[4] <= side_q[3];
      u_q       <= uprod_d[52:24];
    end
  end

  assign u_o    = u_q;
  assign side_o = side_q[PolyStages-1];

endmodule

FILE: hw/rtl/gta_tanh.sv
// Piecewise-linear tanh: segment lookup stage and interpolation stage.
module gta_tanh
  import gta_pkg::*;
#(
  parameter int unsigned TANH_SEGMENTS = TanhSegmentsDef
) (
  input  logic                  clk_i,
  input  logic [TanhStages-1:0] en_i,
  input  logic [UW-1:0]         u_i,
  input  gta_side_t             side_i,
  output logic [TanhW-1:0]      t_o,
  output gta_side_t             side_o
);

  localparam int unsigned SegW  = $clog2(TANH_SEGMENTS + 1);
  localparam int unsigned KW    = $clog2(TANH_SEGMENTS);
  localparam int unsigned PW    = SpanW + SegW;
  localparam tanh_tab_t TanhTab  = tanh_table(TANH_SEGMENTS);
  localparam tanh_tab_t SlopeTab = slope_table(TanhTab, TANH_SEGMENTS);

  logic              sat_d;
  logic [PW-1:0]     pos_d;
  logic [KW-1:0]     seg_d;
  logic [TanhW-1:0]  slope_d;

  logic              sat_q;
  logic [TanhW-1:0]  base_q;
  logic [SlopeW-1:0] slope_q;
  logic [SpanW-1:0]  frac_q;
  gta_side_t         side_s0_q;

  logic [47:0]       rise_d;
  logic [TanhW:0]    sum_d;
  logic [TanhW-1:0]  t_d;
  logic [TanhW-1:0]  t_q;
  gta_side_t         side_s1_q;

  // argument at or beyond 4.0 saturates to one
  assign sat_d   = |u_i[UW-1:SpanW];
  assign pos_d   = PW'(u_i[SpanW-1:0]) * PW'(TANH_SEGMENTS);
  assign seg_d   = pos_d[SpanW +: KW];
  assign slope_d = SlopeTab[TabIdxW'(seg_d)];

  assign rise_d = 48'(slope_q) * 48'(frac_q);
  assign sum_d  = (TanhW+1)'(base_q) + (TanhW+1)'(rise_d[47:SpanW]);

  always_comb begin
    if (sat_q || sum_d > (TanhW+1)'(OneQ24)) begin
      t_d = OneQ24;
    end else begin
      t_d = sum_d[TanhW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sat_q     <= sat_d;
      base_q    <= TanhTab[TabIdxW'(seg_d)];
      slope_q   <= slope_d[SlopeW-1:0];
      frac_q    <= pos_d[SpanW-1:0];
      side_s0_q <= side_i;
    end
    if (en_i[1]) begin
      t_q       <= t_d;
      side_s1_q <= side_s0_q;
    end
  end

  assign t_o    = t_q;
  assign side_o = side_s1_q;

endmodule

FILE: hw/rtl/gta_out.sv
// Output stage: x*(1 +- tanh)/2, round to nearest, restore sign, saturate.
module gta_out
  import gta_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [TanhW-1:0] t_i,
  input  gta_side_t        side_i,
  output logic [DataW-1:0] activation_o
);

  logic [TanhW:0]     factor_d;
  logic [41:0]        prod_d;
  logic [MagW:0]      m_d;
  logic [DataW-1:0]   act_d;
  logic [DataW-1:0]   act_q;

  // negative x uses the odd symmetry of tanh: 1 - t
  assign factor_d = side_i.neg ? (TanhW+1)'(OneQ24) - (TanhW+1)'(t_i)
                               : (TanhW+1)'(OneQ24) + (TanhW+1)'(t_i);
  assign prod_d   = 42'(side_i.mag) * 42'(factor_d) + 42'(OneQ24);
  assign m_d      = prod_d[41:25];

  always_comb begin
    if (!side_i.neg) begin
      act_d = (m_d > 17'd32767) ? 16'h7fff : m_d[DataW-1:0];
    end else begin
      act_d = (m_d > 17'd32767) ? 16'h8000 : DataW'(~m_d[DataW-1:0] + 16'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_q <= act_d;
    end
  end

  assign activation_o = act_q;

endmodule

FILE: hw/rtl/gelu_tanh_activation_core.sv
// GELU (tanh form) activation core: Q3.12 in, Q3.12 out, one item per cycle unless stalled.
// An accepted item passes through the polynomial stages, the tanh lookup and interpolation
// stages and the output stage, and can leave once it is valid and the output is not stalled.
// Throughput: one item per cycle; each stage holds its item only while the stage after
// it is full, so bubbles close up under backpressure.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; the tanh table is constant.
module gelu_tanh_activation_core
  import gta_pkg::*;
#(
  parameter int unsigned TANH_SEGMENTS = TanhSegmentsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [15:0] sample
  input  logic             s_axis_tlast,   // last_in
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,   // [15:0] activation
  output logic             m_axis_tlast    // last_out
);

  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] last_q;
  logic [NumStages-1:0] stage_en;
  logic [NumStages-1:0] valid_in;
  logic [NumStages-1:0] last_in;

  logic [UW-1:0]    u;
  gta_side_t        poly_side;
  logic [TanhW-1:0] tanh_res;
  gta_side_t        tanh_side;

  // a stage loads when it is empty or its item moves on in the same cycle
  assign stage_en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
  for (genvar g = 0; g < NumStages - 1; g++) begin : g_ready
    assign stage_en[g] = !valid_q[g] || stage_en[g+1];
  end

  assign valid_in = {valid_q[NumStages-2:0], s_axis_tvalid};
  assign last_in  = {last_q[NumStages-2:0], s_axis_tlast};
  assign valid_d  = (stage_en & valid_in) | (~stage_en & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumStages; i++) begin
      if (stage_en[i]) begin
        last_q[i] <= last_in[i];
      end
    end
  end

  gta_poly u_gta_poly (
    .clk_i    (clk_i),
    .en_i     (stage_en[PolyStages-1:0]),
    .sample_i (s_axis_tdata),
    .u_o      (u),
    .side_o   (poly_side)
  );

  gta_tanh #(
    .TANH_SEGMENTS (TANH_SEGMENTS)
  ) u_gta_tanh (
    .clk_i  (clk_i),
    .en_i   (stage_en[PolyStages +: TanhStages]),
    .u_i    (u),
    .side_i (poly_side),
    .t_o    (tanh_res),
    .side_o (tanh_side)
  );

  gta_out u_gta_out (
    .clk_i        (clk_i),
    .en_i         (stage_en[NumStages-1]),
    .t_i          (tanh_res),
    .side_i       (tanh_side),
    .activation_o (m_axis_tdata)
  );

  assign s_axis_tready = stage_en[0];
  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tlast  = last_q[NumStages-1];

endmodule

FILE: hw/rtl/gta_checker.sv
// Port-level checks for the GELU tanh activation core, bound to the top level.
module gta_checker
  import gta_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [DataW-1:0] s_axis_tdata,
  input logic             s_axis_tlast,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  // with the output stage empty the whole pipeline can advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output stage is empty");

  // without backpressure an accepted item comes out with its tlast intact
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=>
      m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast, 8)))
    else $error("item missing or tlast wrong after pipeline latency");

  // GELU never falls much below -0.17
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata) >= -16'sd1000))
    else $error("activation below the GELU minimum");

endmodule

bind gelu_tanh_activation_core gta_checker u_gta_checker (.*);
